[rtl/nla_pkg.sv]
package nla_pkg;

    // Light request types; codes 4 to 7 are not supported
    typedef enum logic [2:0] {
        FUNC_BACKLIGHT    = 3'd0,
        FUNC_ATTENTION    = 3'd1,
        FUNC_BATTERY      = 3'd2,
        FUNC_NOTIFICATION = 3'd3
    } func_t;

    // Stored light slots
    localparam int SLOT_COUNT = 3;
    localparam logic [1:0] SLOT_ATTN = 2'd0;
    localparam logic [1:0] SLOT_BATT = 2'd1;
    localparam logic [1:0] SLOT_NOTE = 2'd2;

    // Luma weights, sum 256
    localparam logic [7:0] LUMA_R_COEF = 8'd77;
    localparam logic [7:0] LUMA_G_COEF = 8'd150;
    localparam logic [7:0] LUMA_B_COEF = 8'd29;

    // Ramp pattern
    localparam int RAMP_STEPS = 8;
    localparam int DUTY_W     = 7;

    // x / 255 = (x * DIV255_M) >> DIV255_SHIFT for x below 2**20
    localparam logic [20:0] DIV255_M     = 21'd1052689;
    localparam int          DIV255_SHIFT = 28;

    localparam logic [11:0] MAX_PANEL_RESET = 12'd255;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ALPHA,
        ST_ALPHA_WAIT,
        ST_STORE,
        ST_SELECT,
        ST_LUMA,
        ST_LUMA_WAIT,
        ST_BL,
        ST_BL_DIV,
        ST_DUTY,
        ST_DUTY_WAIT,
        ST_FINISH
    } state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_LUMA_R,
        MUL_LUMA_G,
        MUL_LUMA_B,
        MUL_ALPHA_R,
        MUL_ALPHA_G,
        MUL_ALPHA_B,
        MUL_BL,
        MUL_DIV,
        MUL_DUTY
    } mul_op_t;

    // Where the registered product goes in the cycle after it is formed
    typedef enum logic [2:0] {
        DST_NONE,
        DST_LUMA_CLR,
        DST_LUMA_ADD,
        DST_ALPHA_R,
        DST_ALPHA_G,
        DST_ALPHA_B,
        DST_DUTY
    } dst_t;

    typedef struct packed {
        logic        load;
        mul_op_t     mul;
        dst_t        dst;
        logic [2:0]  idx;
        logic        store;
        logic        select;
        logic        finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       alpha_scale;
        logic       blink;
    } dp_status_t;

    // x / 255 for x up to 65279
    function automatic logic [7:0] div255_small(input logic [15:0] x);
        logic [16:0] t;
        logic [16:0] s;
        t = {1'b0, x} + 17'd1;
        s = t + (t >> 8);
        return s[15:8];
    endfunction

    // Ramp duty table in percent
    function automatic logic [6:0] ramp_pct(input logic [2:0] idx);
        logic [6:0] pct;
        case (idx)
            3'd0:    pct = 7'd0;
            3'd1:    pct = 7'd12;
            3'd2:    pct = 7'd25;
            3'd3:    pct = 7'd37;
            3'd4:    pct = 7'd50;
            3'd5:    pct = 7'd72;
            3'd6:    pct = 7'd85;
            3'd7:    pct = 7'd100;
            default: pct = 7'd0;
        endcase
        return pct;
    endfunction

endpackage

[rtl/notification_led_arbiter.sv]
// Steps before done: dispatch sends unsupported types to finish, backlight runs luma,
// scale and divide, and a stored LED runs alpha if needed, store, select, luma and, if
// blinking, ramp duties. Transactions run one at a time; one shared 21x21 multiplier
// does every product (luma, alpha, backlight scale and divide, ramp duties) in turn.
// Results come with done and stay until the next finish; the receiver cannot stall.
// Reset (rst_n, async low): all stored lights off, max panel brightness 255.
module notification_led_arbiter
    import nla_pkg::*;
#(
    parameter int STEP_MS = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [31:0] color,
    input  logic        flash_timed,
    input  logic [15:0] flash_on_ms,
    input  logic [15:0] flash_off_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    output logic        done,
    output logic        status,
    output logic        backlight_write,
    output logic [11:0] backlight_level,
    output logic        led_update,
    output logic        led_blink_enable,
    output logic [7:0]  led_level,
    output logic [55:0] duty_pcts_packed,
    output logic [15:0] pause_lo_ms,
    output logic [15:0] pause_hi_ms,
    output logic [7:0]  ramp_step_ms
);

    dp_cmd_t    cmd;
    dp_status_t dp_status;
    logic       cfg_we;

    // Register writes are taken whenever no transaction is in flight
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    nla_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    nla_datapath #(
        .STEP_MS (STEP_MS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (dp_status),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .func             (func),
        .color            (color),
        .flash_timed      (flash_timed),
        .flash_on_ms      (flash_on_ms),
        .flash_off_ms     (flash_off_ms),
        .status_out       (status),
        .backlight_write  (backlight_write),
        .backlight_level  (backlight_level),
        .led_update       (led_update),
        .led_blink_enable (led_blink_enable),
        .led_level        (led_level),
        .duty_pcts_packed (duty_pcts_packed),
        .pause_lo_ms      (pause_lo_ms),
        .pause_hi_ms      (pause_hi_ms),
        .ramp_step_ms     (ramp_step_ms)
    );

endmodule

[rtl/nla_ctrl.sv]
module nla_ctrl
    import nla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output logic       done,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       done_reg;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cnt_next = 3'd0;
                case (status.func)
                    FUNC_BACKLIGHT:    state_next = ST_LUMA;
                    FUNC_ATTENTION:    state_next = ST_STORE;
                    FUNC_BATTERY:      state_next = ST_STORE;
                    FUNC_NOTIFICATION: state_next = status.alpha_scale ? ST_ALPHA : ST_STORE;
                    default:           state_next = ST_FINISH;
                endcase
            end
            ST_ALPHA:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        cmd.mul = MUL_ALPHA_R;
                        cmd.dst = DST_ALPHA_R;
                    end
                    3'd1:
                    begin
                        cmd.mul = MUL_ALPHA_G;
                        cmd.dst = DST_ALPHA_G;
                    end
                    default:
                    begin
                        cmd.mul = MUL_ALPHA_B;
                        cmd.dst = DST_ALPHA_B;
                    end
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd2)
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_ALPHA_WAIT;
                end
            end
            ST_ALPHA_WAIT:
            begin
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                cnt_next   = 3'd0;
                state_next = ST_LUMA;
            end
            ST_LUMA:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        cmd.mul = MUL_LUMA_R;
                        cmd.dst = DST_LUMA_CLR;
                    end
                    3'd1:
                    begin
                        cmd.mul = MUL_LUMA_G;
                        cmd.dst = DST_LUMA_ADD;
                    end
                    default:
                    begin
                        cmd.mul = MUL_LUMA_B;
                        cmd.dst = DST_LUMA_ADD;
                    end
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd2)
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_LUMA_WAIT;
                end
            end
            ST_LUMA_WAIT:
            begin
                cnt_next = 3'd0;
                if (status.func == FUNC_BACKLIGHT)
                    state_next = ST_BL;
                else if (status.blink)
                    state_next = ST_DUTY;
                else
                    state_next = ST_FINISH;
            end
            ST_BL:
            begin
                cmd.mul    = MUL_BL;
                state_next = ST_BL_DIV;
            end
            ST_BL_DIV:
            begin
                // product of the previous cycle feeds the reciprocal multiply
                cmd.mul    = MUL_DIV;
                state_next = ST_FINISH;
            end
            ST_DUTY:
            begin
                cmd.mul  = MUL_DUTY;
                cmd.dst  = DST_DUTY;
                cmd.idx  = cnt_reg;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(RAMP_STEPS - 1))
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_DUTY_WAIT;
                end
            end
            ST_DUTY_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // Strobe only follows the finish state
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without finish");

    // An accepted transaction always moves to dispatch
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_DISPATCH))
        else $error("accepted transaction not dispatched");

    // Three-channel sequences never run past the blue channel
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALPHA || state_reg == ST_LUMA) |-> (cnt_reg <= 3'd2))
        else $error("channel counter out of range");
`endif

endmodule

[rtl/nla_datapath.sv]
module nla_datapath
    import nla_pkg::*;
#(
    parameter int STEP_MS = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data,
    input  logic [2:0]  func,
    input  logic [31:0] color,
    input  logic        flash_timed,
    input  logic [15:0] flash_on_ms,
    input  logic [15:0] flash_off_ms,
    output logic        status_out,
    output logic        backlight_write,
    output logic [11:0] backlight_level,
    output logic        led_update,
    output logic        led_blink_enable,
    output logic [7:0]  led_level,
    output logic [55:0] duty_pcts_packed,
    output logic [15:0] pause_lo_ms,
    output logic [15:0] pause_hi_ms,
    output logic [7:0]  ramp_step_ms
);

    // On time below which the ramp is squeezed into the on phase
    localparam logic [15:0] HOLD_MIN = 16'(2 * RAMP_STEPS * STEP_MS);
    localparam logic [7:0]  STEP_V   = 8'(STEP_MS);

    // Control and configuration state
    logic [11:0] max_reg;
    logic [2:0]  func_reg;
    dst_t        dst_reg;
    logic [2:0]  idx_reg;
    logic [23:0] slot_rgb_reg   [SLOT_COUNT];
    logic        slot_timed_reg [SLOT_COUNT];
    logic [15:0] slot_on_reg    [SLOT_COUNT];
    logic [15:0] slot_off_reg   [SLOT_COUNT];

    // Working registers
    logic [41:0] p_reg;
    logic [23:0] wrk_rgb_reg;
    logic [7:0]  alpha_reg;
    logic        sel_timed_reg;
    logic [15:0] sel_on_reg;
    logic [15:0] sel_off_reg;
    logic [15:0] acc_reg;
    logic [55:0] duty_reg;

    // Result registers
    logic        status_reg;
    logic        bl_write_reg;
    logic [11:0] bl_level_reg;
    logic        led_update_reg;
    logic        blink_en_reg;
    logic [7:0]  led_level_reg;
    logic [55:0] duty_out_reg;
    logic [15:0] pause_lo_reg;
    logic [15:0] pause_hi_reg;
    logic [7:0]  ramp_step_reg;

    logic [20:0] mul_a, mul_b;
    logic [41:0] prod;
    logic [7:0]  luma;
    logic [7:0]  q255;
    logic        blink;
    logic        stored;
    logic [1:0]  wr_slot;
    logic [23:0] pick_rgb;
    logic        pick_timed;
    logic [15:0] pick_on, pick_off;
    logic [15:0] hi_val;
    logic [7:0]  step_val;

    assign luma  = acc_reg[15:8];
    assign q255  = div255_small(p_reg[15:0]);
    assign blink = sel_timed_reg && (sel_on_reg != 16'd0) && (sel_off_reg != 16'd0);

    assign status.func        = func_reg;
    assign status.alpha_scale = (alpha_reg != 8'd0) && (alpha_reg != 8'hff);
    assign status.blink       = blink;

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul)
            MUL_LUMA_R:
            begin
                mul_a = 21'(wrk_rgb_reg[23:16]);
                mul_b = 21'(LUMA_R_COEF);
            end
            MUL_LUMA_G:
            begin
                mul_a = 21'(wrk_rgb_reg[15:8]);
                mul_b = 21'(LUMA_G_COEF);
            end
            MUL_LUMA_B:
            begin
                mul_a = 21'(wrk_rgb_reg[7:0]);
                mul_b = 21'(LUMA_B_COEF);
            end
            MUL_ALPHA_R:
            begin
                mul_a = 21'(wrk_rgb_reg[23:16]);
                mul_b = 21'(alpha_reg);
            end
            MUL_ALPHA_G:
            begin
                mul_a = 21'(wrk_rgb_reg[15:8]);
                mul_b = 21'(alpha_reg);
            end
            MUL_ALPHA_B:
            begin
                mul_a = 21'(wrk_rgb_reg[7:0]);
                mul_b = 21'(alpha_reg);
            end
            MUL_BL:
            begin
                mul_a = 21'(luma);
                mul_b = 21'(max_reg);
            end
            MUL_DIV:
            begin
                mul_a = 21'(p_reg[19:0]);
                mul_b = DIV255_M;
            end
            MUL_DUTY:
            begin
                mul_a = 21'(ramp_pct(cmd.idx));
                mul_b = 21'(luma);
            end
            default:
            begin
                mul_a = 21'd0;
                mul_b = 21'd0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Slot written by a store
    always_comb
    begin
        case (func_reg)
            FUNC_ATTENTION: wr_slot = SLOT_ATTN;
            FUNC_BATTERY:   wr_slot = SLOT_BATT;
            default:        wr_slot = SLOT_NOTE;
        endcase
    end

    // Priority pick: notification, attention, battery
    always_comb
    begin
        pick_rgb   = 24'd0;
        pick_timed = 1'b0;
        pick_on    = 16'd0;
        pick_off   = 16'd0;
        if (slot_rgb_reg[SLOT_NOTE] != 24'd0)
        begin
            pick_rgb   = slot_rgb_reg[SLOT_NOTE];
            pick_timed = slot_timed_reg[SLOT_NOTE];
            pick_on    = slot_on_reg[SLOT_NOTE];
            pick_off   = slot_off_reg[SLOT_NOTE];
        end
        else if (slot_rgb_reg[SLOT_ATTN] != 24'd0)
        begin
            pick_rgb   = slot_rgb_reg[SLOT_ATTN];
            pick_timed = slot_timed_reg[SLOT_ATTN];
            pick_on    = slot_on_reg[SLOT_ATTN];
            pick_off   = slot_off_reg[SLOT_ATTN];
        end
        else if (slot_rgb_reg[SLOT_BATT] != 24'd0)
        begin
            pick_rgb   = slot_rgb_reg[SLOT_BATT];
            pick_timed = slot_timed_reg[SLOT_BATT];
            pick_on    = slot_on_reg[SLOT_BATT];
            pick_off   = slot_off_reg[SLOT_BATT];
        end
    end

    // Ramp timing from the on time
    always_comb
    begin
        if (sel_on_reg < HOLD_MIN)
        begin
            step_val = 8'(sel_on_reg >> 4);
            hi_val   = 16'd0;
        end
        else
        begin
            step_val = STEP_V;
            hi_val   = sel_on_reg - HOLD_MIN;
        end
    end

    always_comb
    begin
        stored = (func_reg inside {FUNC_ATTENTION, FUNC_BATTERY, FUNC_NOTIFICATION});
    end

    // Control state, configuration and slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= MAX_PANEL_RESET;
            func_reg <= 3'd0;
            dst_reg  <= DST_NONE;
            idx_reg  <= 3'd0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_rgb_reg[i]   <= 24'd0;
                slot_timed_reg[i] <= 1'b0;
                slot_on_reg[i]    <= 16'd0;
                slot_off_reg[i]   <= 16'd0;
            end
        end
        else
        begin
            if (cfg_we)
                max_reg <= cfg_data;
            if (cmd.load)
                func_reg <= func;
            dst_reg <= cmd.dst;
            idx_reg <= cmd.idx;
            if (cmd.store)
            begin
                slot_rgb_reg[wr_slot]   <= wrk_rgb_reg;
                slot_timed_reg[wr_slot] <= sel_timed_reg;
                slot_on_reg[wr_slot]    <= sel_on_reg;
                slot_off_reg[wr_slot]   <= sel_off_reg;
            end
        end
    end

    // Multiplier product register
    always_ff @(posedge clk)
    begin
        if (cmd.mul != MUL_NONE)
            p_reg <= prod;
    end

    // Working color and flash setting
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wrk_rgb_reg   <= color[23:0];
            alpha_reg     <= color[31:24];
            sel_timed_reg <= flash_timed;
            sel_on_reg    <= flash_on_ms;
            sel_off_reg   <= flash_off_ms;
        end
        else if (cmd.select)
        begin
            wrk_rgb_reg   <= pick_rgb;
            sel_timed_reg <= pick_timed;
            sel_on_reg    <= pick_on;
            sel_off_reg   <= pick_off;
        end
        else
        begin
            case (dst_reg)
                DST_ALPHA_R: wrk_rgb_reg[23:16] <= q255;
                DST_ALPHA_G: wrk_rgb_reg[15:8]  <= q255;
                DST_ALPHA_B: wrk_rgb_reg[7:0]   <= q255;
                default:     wrk_rgb_reg        <= wrk_rgb_reg;
            endcase
        end
    end

    // Luma accumulator and ramp duties
    always_ff @(posedge clk)
    begin
        case (dst_reg)
            DST_LUMA_CLR: acc_reg <= p_reg[15:0];
            DST_LUMA_ADD: acc_reg <= acc_reg + p_reg[15:0];
            DST_DUTY:     duty_reg[DUTY_W * idx_reg +: DUTY_W] <= q255[DUTY_W-1:0];
            default:      acc_reg <= acc_reg;
        endcase
    end

    // Result registers, loaded once per transaction
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg     <= func_reg[2];
            bl_write_reg   <= (func_reg == FUNC_BACKLIGHT);
            bl_level_reg   <= (func_reg == FUNC_BACKLIGHT) ? p_reg[DIV255_SHIFT +: 12] : 12'd0;
            led_update_reg <= stored;
            blink_en_reg   <= stored && blink;
            led_level_reg  <= (stored && !blink) ? luma : 8'd0;
            duty_out_reg   <= (stored && blink) ? duty_reg : 56'd0;
            pause_lo_reg   <= (stored && blink) ? sel_off_reg : 16'd0;
            pause_hi_reg   <= (stored && blink) ? hi_val : 16'd0;
            ramp_step_reg  <= (stored && blink) ? step_val : 8'd0;
        end
    end

    assign status_out       = status_reg;
    assign backlight_write  = bl_write_reg;
    assign backlight_level  = bl_level_reg;
    assign led_update       = led_update_reg;
    assign led_blink_enable = blink_en_reg;
    assign led_level        = led_level_reg;
    assign duty_pcts_packed = duty_out_reg;
    assign pause_lo_ms      = pause_lo_reg;
    assign pause_hi_ms      = pause_hi_reg;
    assign ramp_step_ms     = ramp_step_reg;

endmodule
